@@ design/rational_arithmetic_unit_assert.svh @@
// assertion macros for the rational arithmetic unit
// expects i_clk and i_rst_n in the scope that uses them
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ design/rau_pkg.sv @@
// shared constants for the rational arithmetic unit
// operation codes, status codes and field widths; no dependencies
package rau_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;
    localparam int EXP_W  = 5;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
    localparam logic [OP_W-1:0] OP_POW     = 4'd4;
    localparam logic [OP_W-1:0] OP_EQ      = 4'd5;
    localparam logic [OP_W-1:0] OP_NE      = 4'd6;
    localparam logic [OP_W-1:0] OP_LT      = 4'd7;
    localparam logic [OP_W-1:0] OP_GT      = 4'd8;
    localparam logic [OP_W-1:0] OP_LE      = 4'd9;
    localparam logic [OP_W-1:0] OP_GE      = 4'd10;
    localparam logic [OP_W-1:0] OP_REDUCE  = 4'd11;
    localparam logic [OP_W-1:0] OP_INTPART = 4'd12;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZDEN = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;
    localparam logic [ST_W-1:0] ST_ZNUM = 2'd3;

endpackage

@@ design/rau_in_if.sv @@
// input channel of the rational arithmetic unit
// depends on rau_pkg for field widths
interface rau_in_if;
    logic                               valid;
    logic                               ready;
    logic [rau_pkg::OP_W-1:0]           operation;
    logic signed [rau_pkg::DATA_W-1:0]  a_num;
    logic signed [rau_pkg::DATA_W-1:0]  a_den;
    logic signed [rau_pkg::DATA_W-1:0]  b_num;
    logic signed [rau_pkg::DATA_W-1:0]  b_den;
    logic [rau_pkg::EXP_W-1:0]          exponent;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, exponent,
                    input ready);
    modport sink   (input valid, operation, a_num, a_den, b_num, b_den, exponent,
                    output ready);
endinterface

@@ design/rau_out_if.sv @@
// result channel of the rational arithmetic unit
// depends on rau_pkg for field widths
interface rau_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rau_pkg::DATA_W-1:0]  result_num;
    logic signed [rau_pkg::DATA_W-1:0]  result_den;
    logic                               truth;
    logic signed [rau_pkg::DATA_W-1:0]  whole_part;
    logic [rau_pkg::DATA_W-1:0]         common_divisor;
    logic [rau_pkg::ST_W-1:0]           status;

    modport source (output valid, result_num, result_den, truth, whole_part,
                    common_divisor, status, input ready);
    modport sink   (input valid, result_num, result_den, truth, whole_part,
                    common_divisor, status, output ready);
endinterface

@@ design/rau_mul.sv @@
// shared unsigned multiplier with registered product
// depends on rau_pkg for the operand width
module rau_mul (
    input  logic                           i_clk,
    input  logic [rau_pkg::DATA_W-1:0]     i_a,
    input  logic [rau_pkg::DATA_W-1:0]     i_b,
    output logic [2*rau_pkg::DATA_W-1:0]   o_p
);
    localparam int DW = rau_pkg::DATA_W;

    logic [2*DW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {{DW{1'b0}}, i_a} * {{DW{1'b0}}, i_b};
    end

    assign o_p = r_p;
endmodule

@@ design/rau_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on rau_pkg for the operand width
module rau_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rau_pkg::DATA_W-1:0]  i_dividend,
    input  logic [rau_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [rau_pkg::DATA_W-1:0]  o_quot,
    output logic [rau_pkg::DATA_W-1:0]  o_rem
);
    localparam int DW = rau_pkg::DATA_W;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;

    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          ge;

    assign trial = {r_r, r_q[DW-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_d};
    assign ge    = !diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_r   <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ design/rational_arithmetic_unit.sv @@
// Fraction ALU: one item in, one result out, one item at a time. Add, sub, mul, div and
// the comparisons make three passes through the shared multiplier. Power makes four
// multiplier passes per factor for an exponent above 1 and none for an exponent of 0
// or 1. Intpart takes one pass of the divider. Reduce takes the binary gcd plus two
// divider passes. Input is refused while an item is at work; a finished result waits
// in the output register.
// depends on rau_pkg, rau_in_if, rau_out_if, rau_mul, rau_div and the assertion header
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int DW = rau_pkg::DATA_W;
    localparam logic [DW-1:0] LIM = DW'(1) << (DW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_MUL, S_FIN, S_POW, S_PFIN,
        S_GCD, S_RDIV1, S_RDIV2, S_IDIV, S_OUT
    } t_state;

    function automatic logic fits_w(input logic [DW-1:0] m, input logic neg);
        return neg ? (m <= LIM) : (m < LIM);
    endfunction

    function automatic logic fits_p(input logic signed [2*DW:0] v);
        return (v[2*DW:DW-1] == '0) || (v[2*DW:DW-1] == '1);
    endfunction

    t_state                    r_state;
    logic [rau_pkg::OP_W-1:0]  r_op;
    logic [DW-1:0]             r_an, r_ad, r_bn, r_bd;
    logic [rau_pkg::EXP_W-1:0] r_ex;
    logic                      r_zden;
    logic [2:0]                r_step;
    logic [2*DW-1:0]           r_p0, r_p1, r_p2;
    logic [DW-1:0]             r_wn, r_wd, r_mn, r_md;
    logic                      r_big;
    logic [rau_pkg::EXP_W-1:0] r_cnt;
    logic [DW-1:0]             r_u, r_v;
    logic [rau_pkg::EXP_W-1:0] r_k;
    logic [DW-1:0]             r_q1;
    logic                      r_div_start;
    logic [DW-1:0]             r_rn, r_rd, r_whole, r_g;
    logic                      r_truth;
    logic [rau_pkg::ST_W-1:0]  r_st;
    logic                      r_ovalid;
    logic [DW-1:0]             r_o_rn, r_o_rd, r_o_whole, r_o_g;
    logic                      r_o_truth;
    logic [rau_pkg::ST_W-1:0]  r_o_st;

    logic [DW-1:0]   man, mad, mbn, mbd;
    logic            zd;
    logic [DW-1:0]   mul_a, mul_b;
    logic [2*DW-1:0] mul_p;
    logic [DW-1:0]   div_n, div_d, div_q, div_r;
    logic            div_busy, div_done;
    logic            div_go;
    logic            keep_a;
    logic            s0, s1, s2;
    logic [2*DW:0]   u0, u1, u2;
    logic signed [2*DW:0] v0, v1, v2, vx;
    logic            truth_c;
    logic [DW-1:0]   gval;
    logic            pn_neg, pd_neg;
    logic            q1_neg, q2_neg, w_neg, x_neg;

    assign man = r_an[DW-1] ? (DW'(0) - r_an) : r_an;
    assign mad = r_ad[DW-1] ? (DW'(0) - r_ad) : r_ad;
    assign mbn = r_bn[DW-1] ? (DW'(0) - r_bn) : r_bn;
    assign mbd = r_bd[DW-1] ? (DW'(0) - r_bd) : r_bd;

    assign zd = ((r_op <= rau_pkg::OP_INTPART) && (mad == '0))
             || ((r_op <= rau_pkg::OP_GE) && (mbd == '0))
             || ((r_op == rau_pkg::OP_DIV) && (mbn == '0));

    // items that return a unchanged straight from decode
    assign keep_a = ((r_op == rau_pkg::OP_POW) && (r_ex <= rau_pkg::EXP_W'(1)))
                 || ((r_op == rau_pkg::OP_REDUCE) && (zd || (man == '0)))
                 || ((r_op == rau_pkg::OP_INTPART) && zd);

    assign div_go = ((r_state == S_DEC) && (r_op == rau_pkg::OP_INTPART) && !zd)
                 || ((r_state == S_GCD) && ((r_u == '0) || (r_v == '0)))
                 || ((r_state == S_RDIV1) && div_done);

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                3'd0: begin
                    mul_a = man;
                    mul_b = (r_op == rau_pkg::OP_MUL) ? mbn : mbd;
                end
                3'd1: begin
                    mul_a = mbn;
                    mul_b = mad;
                end
                default: begin
                    mul_a = mad;
                    mul_b = (r_op == rau_pkg::OP_DIV) ? mbn : mbd;
                end
            endcase
        end else if (r_state == S_POW) begin
            case (r_step)
                3'd0: begin
                    mul_a = r_wn;
                    mul_b = r_an;
                end
                3'd1: begin
                    mul_a = r_wd;
                    mul_b = r_ad;
                end
                3'd2: begin
                    mul_a = r_mn;
                    mul_b = man;
                end
                default: begin
                    mul_a = r_md;
                    mul_b = mad;
                end
            endcase
        end
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        div_n = man;
        div_d = mad;
        if (r_state == S_RDIV1) begin
            div_d = r_g;
        end else if (r_state == S_RDIV2) begin
            div_n = mad;
            div_d = r_g;
        end
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // cross product signs and signed values
    assign s0 = r_an[DW-1] ^ ((r_op == rau_pkg::OP_MUL) ? r_bn[DW-1] : r_bd[DW-1]);
    assign s1 = r_bn[DW-1] ^ r_ad[DW-1] ^ (r_op == rau_pkg::OP_SUB);
    assign s2 = r_ad[DW-1] ^ ((r_op == rau_pkg::OP_DIV) ? r_bn[DW-1] : r_bd[DW-1]);
    assign u0 = {1'b0, r_p0};
    assign u1 = {1'b0, r_p1};
    assign u2 = {1'b0, r_p2};
    assign v0 = s0 ? $signed((2*DW+1)'(0) - u0) : $signed(u0);
    assign v1 = s1 ? $signed((2*DW+1)'(0) - u1) : $signed(u1);
    assign v2 = s2 ? $signed((2*DW+1)'(0) - u2) : $signed(u2);
    assign vx = ((r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB)) ? (v0 + v1) : v0;

    always_comb begin
        case (r_op)
            rau_pkg::OP_EQ: truth_c = (v0 == v1);
            rau_pkg::OP_NE: truth_c = (v0 != v1);
            rau_pkg::OP_LT: truth_c = (v0 < v1);
            rau_pkg::OP_GT: truth_c = (v0 > v1);
            rau_pkg::OP_LE: truth_c = (v0 <= v1);
            default:        truth_c = (v0 >= v1);
        endcase
    end

    assign gval   = (r_u == '0) ? (r_v << r_k) : (r_u << r_k);
    assign pn_neg = r_an[DW-1] && r_ex[0] && (r_mn != '0);
    assign pd_neg = r_ad[DW-1] && r_ex[0] && (r_md != '0);
    assign q1_neg = r_an[DW-1] && (r_q1 != '0);
    assign q2_neg = r_ad[DW-1] && (div_q != '0);
    assign w_neg  = (r_an[DW-1] ^ r_ad[DW-1]) && (div_q != '0);
    assign x_neg  = r_an[DW-1] && (div_r != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_start <= div_go;
            r_ovalid    <= (r_state == S_OUT) || (r_ovalid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.operation;
                        r_an    <= i_in.a_num;
                        r_ad    <= i_in.a_den;
                        r_bn    <= i_in.b_num;
                        r_bd    <= i_in.b_den;
                        r_ex    <= i_in.exponent;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_rn    <= keep_a ? r_an : '0;
                    r_rd    <= keep_a ? r_ad : '0;
                    r_truth <= 1'b0;
                    r_whole <= '0;
                    r_g     <= '0;
                    r_st    <= !keep_a ? rau_pkg::ST_OK :
                               (zd ? rau_pkg::ST_ZDEN :
                                ((r_op == rau_pkg::OP_REDUCE) ? rau_pkg::ST_ZNUM
                                                              : rau_pkg::ST_OK));
                    r_zden  <= zd;
                    r_step  <= '0;
                    unique case (r_op) inside
                        [rau_pkg::OP_ADD:rau_pkg::OP_DIV], [rau_pkg::OP_EQ:rau_pkg::OP_GE]: begin
                            r_state <= S_MUL;
                        end
                        rau_pkg::OP_POW: begin
                            if (r_ex <= rau_pkg::EXP_W'(1)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_wn    <= r_an;
                                r_wd    <= r_ad;
                                r_mn    <= man;
                                r_md    <= mad;
                                r_big   <= 1'b0;
                                r_cnt   <= rau_pkg::EXP_W'(1);
                                r_state <= S_POW;
                            end
                        end
                        rau_pkg::OP_REDUCE: begin
                            if (zd || (man == '0)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_u     <= man;
                                r_v     <= mad;
                                r_k     <= '0;
                                r_state <= S_GCD;
                            end
                        end
                        rau_pkg::OP_INTPART: begin
                            if (zd) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_IDIV;
                            end
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_p0 <= mul_p;
                        3'd2: r_p1 <= mul_p;
                        3'd3: begin
                            r_p2    <= mul_p;
                            r_state <= S_FIN;
                        end
                        default: ;
                    endcase
                end
                S_FIN: begin
                    if (r_op <= rau_pkg::OP_DIV) begin
                        r_rn <= vx[DW-1:0];
                        r_rd <= v2[DW-1:0];
                        r_st <= r_zden ? rau_pkg::ST_ZDEN :
                                ((!fits_p(vx) || !fits_p(v2)) ? rau_pkg::ST_OVF
                                                              : rau_pkg::ST_OK);
                    end else begin
                        r_truth <= truth_c;
                        r_st    <= r_zden ? rau_pkg::ST_ZDEN : rau_pkg::ST_OK;
                    end
                    r_state <= S_OUT;
                end
                S_POW: begin
                    r_step <= (r_step == 3'd4) ? 3'd0 : (r_step + 3'd1);
                    case (r_step)
                        3'd1: r_wn <= mul_p[DW-1:0];
                        3'd2: r_wd <= mul_p[DW-1:0];
                        3'd3: begin
                            r_mn <= mul_p[DW-1:0];
                            if (mul_p[2*DW-1:DW] != '0) begin
                                r_big <= 1'b1;
                            end
                        end
                        3'd4: begin
                            r_md   <= mul_p[DW-1:0];
                            if (mul_p[2*DW-1:DW] != '0) begin
                                r_big <= 1'b1;
                            end
                            if ((r_cnt + rau_pkg::EXP_W'(1)) == r_ex) begin
                                r_state <= S_PFIN;
                            end else begin
                                r_cnt <= r_cnt + rau_pkg::EXP_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                S_PFIN: begin
                    r_rn <= r_wn;
                    r_rd <= r_wd;
                    r_st <= r_zden ? rau_pkg::ST_ZDEN :
                            ((r_big || !fits_w(r_mn, pn_neg) || !fits_w(r_md, pd_neg))
                             ? rau_pkg::ST_OVF : rau_pkg::ST_OK);
                    r_state <= S_OUT;
                end
                S_GCD: begin
                    if ((r_u == '0) || (r_v == '0)) begin
                        r_g         <= gval;
                        r_state     <= S_RDIV1;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + rau_pkg::EXP_W'(1);
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
                S_RDIV1: begin
                    if (div_done) begin
                        r_q1        <= div_q;
                        r_state     <= S_RDIV2;
                    end
                end
                S_RDIV2: begin
                    if (div_done) begin
                        r_rn <= q1_neg ? (DW'(0) - r_q1) : r_q1;
                        r_rd <= q2_neg ? (DW'(0) - div_q) : div_q;
                        r_st <= (!fits_w(r_q1, q1_neg) || !fits_w(div_q, q2_neg))
                                ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_IDIV: begin
                    if (div_done) begin
                        r_whole <= w_neg ? (DW'(0) - div_q) : div_q;
                        r_rn    <= x_neg ? (DW'(0) - div_r) : div_r;
                        r_rd    <= r_ad;
                        r_st    <= (!fits_w(div_q, w_neg) || !fits_w(div_r, x_neg))
                                   ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_o_rn    <= r_rn;
                        r_o_rd    <= r_rd;
                        r_o_truth <= r_truth;
                        r_o_whole <= r_whole;
                        r_o_g     <= r_g;
                        r_o_st    <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.result_num     = $signed(r_o_rn);
    assign o_out.result_den     = $signed(r_o_rd);
    assign o_out.truth          = r_o_truth;
    assign o_out.whole_part     = $signed(r_o_whole);
    assign o_out.common_divisor = r_o_g;
    assign o_out.status         = r_o_st;

    `RAU_ASSERT_IMP(a_div_start_idle, r_div_start, !div_busy)
    `RAU_ASSERT_IMP(a_div_done_waited, div_done,
        (r_state == S_RDIV1) || (r_state == S_RDIV2) || (r_state == S_IDIV))
    `RAU_ASSERT_IMP(a_pow_count, r_state == S_POW, r_cnt < r_ex)
    `RAU_ASSERT_NXT(a_busy_after_transfer, i_in.valid && i_in.ready, !i_in.ready)
endmodule

@@ tb/rau_checker.sv @@
// result checker for the rational arithmetic unit: watches both channels,
// predicts each result from the accepted operands and compares field by field
// depends on rau_pkg, rau_in_if and rau_out_if
module rau_checker
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if         in_ch,
    rau_out_if        out_ch,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] m;
        bit          n;
    } smag_t;

    typedef struct packed {
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        logic              truth;
        logic [DATA_W-1:0] whole;
        logic [DATA_W-1:0] gcd;
        logic [ST_W-1:0]   status;
    } frac_result_t;

    frac_result_t expected_results[$];
    int fails;
    int results;

    function automatic logic [63:0] sext(logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic smag_t to_mag(logic [31:0] x);
        smag_t s;
        logic [63:0] v;
        v = sext(x);
        s.n = v[63];
        s.m = s.n ? (64'd0 - v) : v;
        return s;
    endfunction

    function automatic smag_t mag_mul(smag_t a, smag_t b);
        smag_t r;
        r.m = a.m * b.m;
        r.n = (r.m != 0) && (a.n != b.n);
        return r;
    endfunction

    function automatic smag_t mag_add(smag_t a, smag_t b);
        smag_t r;
        if (a.n == b.n) begin
            r.m = a.m + b.m;
            r.n = a.n;
        end else if (a.m >= b.m) begin
            r.m = a.m - b.m;
            r.n = a.n;
        end else begin
            r.m = b.m - a.m;
            r.n = b.n;
        end
        if (r.m == 0) r.n = 0;
        return r;
    endfunction

    function automatic bit fits(smag_t s);
        logic [63:0] lim;
        lim = 64'd1 << (DATA_W - 1);
        return s.n ? (s.m <= lim) : (s.m < lim);
    endfunction

    function automatic logic [31:0] signed_val(smag_t s);
        logic [63:0] v;
        v = s.n ? (64'd0 - s.m) : s.m;
        return v[31:0];
    endfunction

    function automatic frac_result_t predict_fraction(
        logic [OP_W-1:0] op, logic [31:0] a_n, logic [31:0] a_d,
        logic [31:0] b_n, logic [31:0] b_d, logic [EXP_W-1:0] ex);
        frac_result_t r;
        smag_t an, ad, bn, bd, x, y, t, w, xn, xd;
        logic [63:0] wn, wd, fn, fd, g, p, q, tmp;
        longint l, rr;
        bit zden, ovf, big;
        an = to_mag(a_n);
        ad = to_mag(a_d);
        bn = to_mag(b_n);
        bd = to_mag(b_d);
        r = '0;
        zden = 0;
        ovf = 0;
        if (op <= OP_GE) zden = (ad.m == 0) || (bd.m == 0);
        else if (op <= OP_INTPART) zden = (ad.m == 0);
        if (op == OP_DIV && bn.m == 0) zden = 1;
        if (op <= OP_DIV) begin
            if (op == OP_ADD || op == OP_SUB) begin
                t = mag_mul(bn, ad);
                if (op == OP_SUB && t.m != 0) t.n = !t.n;
                x = mag_add(mag_mul(an, bd), t);
                y = mag_mul(ad, bd);
            end else if (op == OP_MUL) begin
                x = mag_mul(an, bn);
                y = mag_mul(ad, bd);
            end else begin
                x = mag_mul(an, bd);
                y = mag_mul(ad, bn);
            end
            ovf = !fits(x) || !fits(y);
            r.num = signed_val(x);
            r.den = signed_val(y);
        end else if (op == OP_POW) begin
            wn = sext(a_n);
            wd = sext(a_d);
            fn = wn;
            fd = wd;
            xn = an;
            xd = ad;
            big = 0;
            for (int i = 1; i < ex; i++) begin
                wn = wn * fn;
                wd = wd * fd;
                if (!big) begin
                    if ((an.m != 0 && xn.m > 64'hFFFF_FFFF_FFFF_FFFF / an.m) ||
                        (ad.m != 0 && xd.m > 64'hFFFF_FFFF_FFFF_FFFF / ad.m)) begin
                        big = 1;
                    end else begin
                        xn = mag_mul(xn, an);
                        xd = mag_mul(xd, ad);
                    end
                end
            end
            ovf = big || !fits(xn) || !fits(xd);
            r.num = wn[31:0];
            r.den = wd[31:0];
        end else if (op <= OP_GE) begin
            l = longint'(signed'(a_n)) * longint'(signed'(b_d));
            rr = longint'(signed'(b_n)) * longint'(signed'(a_d));
            case (op)
                OP_EQ:   r.truth = (l == rr);
                OP_NE:   r.truth = (l != rr);
                OP_LT:   r.truth = (l < rr);
                OP_GT:   r.truth = (l > rr);
                OP_LE:   r.truth = (l <= rr);
                default: r.truth = (l >= rr);
            endcase
        end else if (op <= OP_INTPART) begin
            x = an;
            y = ad;
            w = '0;
            g = 0;
            if (!zden && op == OP_REDUCE && an.m != 0) begin
                p = an.m;
                q = ad.m;
                while (q != 0) begin
                    tmp = p % q;
                    p = q;
                    q = tmp;
                end
                g = p;
                x.m = an.m / g;
                y.m = ad.m / g;
            end else if (!zden && op == OP_INTPART) begin
                w.m = an.m / ad.m;
                w.n = (w.m != 0) && (an.n != ad.n);
                x.m = an.m % ad.m;
                x.n = (x.m != 0) && an.n;
            end
            if (op == OP_REDUCE && !zden && an.m == 0) r.status = ST_ZNUM;
            ovf = !fits(x) || !fits(y) || !fits(w);
            r.num = signed_val(x);
            r.den = signed_val(y);
            r.whole = signed_val(w);
            r.gcd = g[31:0];
        end
        if (zden) r.status = ST_ZDEN;
        else if (r.status == ST_OK && ovf) r.status = ST_OVF;
        return r;
    endfunction

    always @(posedge i_clk) begin
        frac_result_t e;
        if (!i_rst_n) begin
            expected_results.delete();
            fails <= 0;
            results <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_fraction(in_ch.operation, in_ch.a_num,
                    in_ch.a_den, in_ch.b_num, in_ch.b_den, in_ch.exponent));
            if (out_ch.valid && out_ch.ready) begin
                results <= results + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fails <= fails + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (out_ch.result_num !== e.num ||
                        out_ch.result_den !== e.den ||
                        out_ch.truth !== e.truth ||
                        out_ch.whole_part !== e.whole ||
                        out_ch.common_divisor !== e.gcd ||
                        out_ch.status !== e.status)
                        fails <= fails + 1;
                    if (out_ch.result_num !== e.num)
                        $error("result_num expected %h actual %h", e.num, out_ch.result_num);
                    if (out_ch.result_den !== e.den)
                        $error("result_den expected %h actual %h", e.den, out_ch.result_den);
                    if (out_ch.truth !== e.truth)
                        $error("truth expected %b actual %b", e.truth, out_ch.truth);
                    if (out_ch.whole_part !== e.whole)
                        $error("whole_part expected %h actual %h", e.whole, out_ch.whole_part);
                    if (out_ch.common_divisor !== e.gcd)
                        $error("common_divisor expected %h actual %h", e.gcd,
                               out_ch.common_divisor);
                    if (out_ch.status !== e.status)
                        $error("status expected %0d actual %0d", e.status, out_ch.status);
                end
            end
        end
    end

    assign o_fail_count = fails;
    assign o_pending = expected_results.size();
    assign o_result_count = results;
endmodule

@@ tb/tb_rational_arithmetic_unit.sv @@
// top of the rational arithmetic unit testbench: clock, reset, operand
// stimulus with bursty sending and a stalling receiver, and the verdict
// depends on rau_pkg, rau_in_if, rau_out_if, rau_checker and the unit
module tb_rational_arithmetic_unit;
    import rau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 4'd15;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 950;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   burst_left;
    int   sent;
    int   fail_count, pending, result_count;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    rau_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: alternates free-running stretches with random stalls
    always @(posedge i_clk) begin
        if (cycles[8])
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd, logic [EXP_W-1:0] ex);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.a_num     <= an;
        in_ch.a_den     <= ad;
        in_ch.b_num     <= bn;
        in_ch.b_den     <= bd;
        in_ch.exponent  <= ex;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        sent++;
        if (burst_left == 0) in_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'sd0 - $urandom_range(0, 20);
            2:       return $urandom_range(0, 20);
            3:       return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            4:       return $urandom_range(0, 65535) * $urandom_range(1, 12);
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return pick_value();
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    initial begin
        logic [OP_W-1:0] op;
        logic [EXP_W-1:0] ex;
        cycles = 0;
        burst_left = 0;
        sent = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.operation = OP_ADD;
        in_ch.a_num = 0;
        in_ch.a_den = 0;
        in_ch.b_num = 0;
        in_ch.b_den = 0;
        in_ch.exponent = 0;
        out_ch.ready = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 0);
        send_item(OP_SUB, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd3, 0);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5, 0);
        send_item(OP_DIV, -32'sd7, 32'd2, 32'd3, -32'sd5, 0);
        send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2, 0);
        send_item(OP_POW, 32'd3, 32'd5, 0, 1, 5'd0);
        send_item(OP_POW, -32'sd3, 32'd5, 0, 1, 5'd1);
        send_item(OP_POW, -32'sd2, 32'd3, 0, 1, 5'd7);
        send_item(OP_POW, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1, 5'd31);
        send_item(OP_EQ, 32'd1, 32'd2, 32'd2, 32'd4, 0);
        send_item(OP_NE, 32'd1, 32'd2, 32'd2, 32'd4, 0);
        send_item(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 0);
        send_item(OP_GT, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'd1, 0);
        send_item(OP_LE, 32'd5, 32'd7, 32'd5, 32'd7, 0);
        send_item(OP_GE, 32'd4, 32'd7, 32'd5, 32'd7, 0);
        send_item(OP_EQ, 32'd4, 32'd7, 32'd5, 32'd0, 0);
        send_item(OP_REDUCE, 32'd84, -32'sd36, 0, 0, 0);
        send_item(OP_REDUCE, 32'd0, 32'd9, 0, 0, 0);
        send_item(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_item(OP_REDUCE, 32'd6, 32'd0, 0, 0, 0);
        send_item(OP_INTPART, -32'sd17, 32'd5, 0, 0, 0);
        send_item(OP_INTPART, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(OP_INTPART, 32'd9, 32'd0, 0, 0, 0);
        send_item(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 5'h1F);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            op = OP_W'($urandom_range(0, 15));
            ex = ($urandom_range(0, 9) == 0) ? EXP_W'($urandom_range(0, 31))
                                             : EXP_W'($urandom_range(0, 4));
            send_item(op, pick_value(), pick_den(), pick_value(), pick_den(), ex);
            if (k == RANDOM_ITEMS / 2) begin
                if (burst_left != 0) in_ch.valid <= 1'b0;
                burst_left = 0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        if (burst_left != 0) in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operand transfers, %0d results: all thirteen operations, unknown codes,",
                 sent, result_count);
        $display("zero denominators, wrapping, gcd reduce and integer split exercised");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
